// ===== hw/rtl/at2i_pkg.sv =====
package at2i_pkg;

    // bits of the unsigned q0.16 ratio and the divider layout
    localparam int RATIO_BITS     = 16;
    localparam int DIV_STEP_BITS  = 2;
    localparam int DIV_STAGES     = RATIO_BITS / DIV_STEP_BITS;
    localparam int INTERP_STAGES  = 4;
    localparam int SERIES_TERMS   = 24;

    localparam logic [63:0] PI_Q32         = 64'h0000_0003_243F_6A88;
    localparam logic [63:0] HALF_PI_Q32    = 64'h0000_0001_921F_B544;
    localparam logic [63:0] QUARTER_PI_Q32 = 64'h0000_0000_C90F_DAA2;

    // octant and special-case flags that ride along with each beat
    typedef struct packed {
        logic y_neg;
        logic x_neg;
        logic zero;
        logic equal;
        logic steep;
    } t_ctl;

    // elaboration-time long division, one quotient bit per pass
    function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
        logic [64:0] rem;
        logic [63:0] quo;
        rem = '0;
        quo = '0;
        for (int b = 63; b >= 0; b--) begin
            rem = {rem[63:0], num[b]};
            if (rem >= {1'b0, den}) begin
                rem    = rem - {1'b0, den};
                quo[b] = 1'b1;
            end
        end
        return quo;
    endfunction

    // atan(p/q) in q0.32 for p/q up to one half
    function automatic logic [63:0] series_atan(input logic [63:0] p, input logic [63:0] q);
        logic [63:0] t;
        logic [63:0] t2;
        logic [63:0] term;
        logic [63:0] acc;
        logic [63:0] d;
        t    = udiv64(p << 32, q);
        t2   = (t * t) >> 32;
        term = t;
        acc  = t;
        for (int k = 1; k <= SERIES_TERMS; k++) begin
            term = (term * t2) >> 32;
            d    = udiv64(term, 64'(2 * k + 1));
            if (k % 2 == 1) begin
                acc = acc - d;
            end else begin
                acc = acc + d;
            end
        end
        return acc;
    endfunction

    // atan(i/m) in q0.32, reduced about pi/4 above one half
    function automatic logic [63:0] sample_atan(input logic [63:0] i, input logic [63:0] m);
        if (2 * i <= m) begin
            return series_atan(i, m);
        end
        return QUARTER_PI_Q32 - series_atan(m - i, m + i);
    endfunction

    // q0.32 to angle format, rounded half up
    function automatic logic [63:0] to_angle(input logic [63:0] v, input int frac);
        return (v + (64'd1 << (31 - frac))) >> (32 - frac);
    endfunction

    function automatic logic [63:0] table_entry(input int idx, input int last, input int frac,
                                                input logic steep);
        logic [63:0] a;
        a = sample_atan(64'(idx), 64'(last));
        if (steep) begin
            return to_angle(HALF_PI_Q32 - a, frac);
        end
        return to_angle(a, frac);
    endfunction

    function automatic logic [63:0] pi_angle(input int frac);
        return to_angle(PI_Q32, frac);
    endfunction

endpackage

// ===== hw/rtl/at2i_front.sv =====
module at2i_front #(
    parameter int INPUT_WIDTH = 16
) (
    input  logic                          i_clk,
    input  logic                          i_en,
    input  logic signed [INPUT_WIDTH-1:0] i_y_value,
    input  logic signed [INPUT_WIDTH-1:0] i_x_value,
    output logic [INPUT_WIDTH:0]          o_rem,
    output logic [INPUT_WIDTH-1:0]        o_den,
    output at2i_pkg::t_ctl                o_ctl
);

    logic [INPUT_WIDTH-1:0] w_ay;
    logic [INPUT_WIDTH-1:0] w_ax;
    logic [INPUT_WIDTH:0]   n_rem;
    logic [INPUT_WIDTH-1:0] n_den;
    at2i_pkg::t_ctl         n_ctl;
    logic [INPUT_WIDTH:0]   r_rem;
    logic [INPUT_WIDTH-1:0] r_den;
    at2i_pkg::t_ctl         r_ctl;

    // most negative input keeps its exact magnitude in w bits unsigned
    assign w_ay = i_y_value[INPUT_WIDTH-1] ? (~i_y_value + 1'b1) : i_y_value;
    assign w_ax = i_x_value[INPUT_WIDTH-1] ? (~i_x_value + 1'b1) : i_x_value;

    always_comb begin
        n_ctl.y_neg = i_y_value[INPUT_WIDTH-1];
        n_ctl.x_neg = i_x_value[INPUT_WIDTH-1];
        n_ctl.zero  = (w_ay == '0) && (w_ax == '0);
        n_ctl.equal = (w_ay == w_ax);
        n_ctl.steep = (w_ay >= w_ax);
        n_rem       = {1'b0, (n_ctl.steep ? w_ax : w_ay)};
        n_den       = n_ctl.steep ? w_ay : w_ax;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem <= n_rem;
            r_den <= n_den;
            r_ctl <= n_ctl;
        end
    end

    assign o_rem = r_rem;
    assign o_den = r_den;
    assign o_ctl = r_ctl;

endmodule

// ===== hw/rtl/at2i_div_step.sv =====
module at2i_div_step #(
    parameter int INPUT_WIDTH = 16
) (
    input  logic                              i_clk,
    input  logic                              i_en,
    input  logic [INPUT_WIDTH:0]              i_rem,
    input  logic [INPUT_WIDTH-1:0]            i_den,
    input  logic [at2i_pkg::RATIO_BITS-1:0]   i_quo,
    input  at2i_pkg::t_ctl                    i_ctl,
    output logic [INPUT_WIDTH:0]              o_rem,
    output logic [INPUT_WIDTH-1:0]            o_den,
    output logic [at2i_pkg::RATIO_BITS-1:0]   o_quo,
    output at2i_pkg::t_ctl                    o_ctl
);

    logic [INPUT_WIDTH:0]            n_rem;
    logic [at2i_pkg::RATIO_BITS-1:0] n_quo;
    logic [INPUT_WIDTH:0]            v_shift;
    logic [INPUT_WIDTH:0]            r_rem;
    logic [INPUT_WIDTH-1:0]          r_den;
    logic [at2i_pkg::RATIO_BITS-1:0] r_quo;
    at2i_pkg::t_ctl                  r_ctl;

    // restoring division, DIV_STEP_BITS quotient bits per stage
    always_comb begin
        n_rem   = i_rem;
        n_quo   = i_quo;
        v_shift = '0;
        for (int b = 0; b < at2i_pkg::DIV_STEP_BITS; b++) begin
            v_shift = {n_rem[INPUT_WIDTH-1:0], 1'b0};
            if (v_shift >= {1'b0, i_den}) begin
                n_rem = v_shift - {1'b0, i_den};
                n_quo = {n_quo[at2i_pkg::RATIO_BITS-2:0], 1'b1};
            end else begin
                n_rem = v_shift;
                n_quo = {n_quo[at2i_pkg::RATIO_BITS-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem <= n_rem;
            r_den <= i_den;
            r_quo <= n_quo;
            r_ctl <= i_ctl;
        end
    end

    assign o_rem = r_rem;
    assign o_den = r_den;
    assign o_quo = r_quo;
    assign o_ctl = r_ctl;

endmodule

// ===== hw/rtl/at2i_interp.sv =====
module at2i_interp #(
    parameter int TABLE_ENTRIES       = 100,
    parameter int ANGLE_FRACTION_BITS = 13
) (
    input  logic                                  i_clk,
    input  logic [at2i_pkg::INTERP_STAGES-1:0]    i_en,
    input  logic [at2i_pkg::RATIO_BITS-1:0]       i_quo,
    input  at2i_pkg::t_ctl                        i_ctl,
    output logic [ANGLE_FRACTION_BITS+2:0]        o_ans,
    output at2i_pkg::t_ctl                        o_ctl
);

    localparam int AW = ANGLE_FRACTION_BITS + 3;
    localparam int KW = $clog2(TABLE_ENTRIES);
    localparam int RB = at2i_pkg::RATIO_BITS;
    localparam int PW = RB + KW;
    localparam logic [AW-1:0] LAST_STEEP =
        AW'(at2i_pkg::table_entry(TABLE_ENTRIES - 1, TABLE_ENTRIES - 1,
                                  ANGLE_FRACTION_BITS, 1'b1));

    logic [AW-1:0] w_steep   [TABLE_ENTRIES];
    logic [AW-1:0] w_shallow [TABLE_ENTRIES];

    for (genvar g = 0; g < TABLE_ENTRIES; g++) begin : g_rom
        localparam logic [AW-1:0] STEEP_VAL =
            AW'(at2i_pkg::table_entry(g, TABLE_ENTRIES - 1, ANGLE_FRACTION_BITS, 1'b1));
        localparam logic [AW-1:0] SHALLOW_VAL =
            AW'(at2i_pkg::table_entry(g, TABLE_ENTRIES - 1, ANGLE_FRACTION_BITS, 1'b0));
        assign w_steep[g]   = STEEP_VAL;
        assign w_shallow[g] = SHALLOW_VAL;
    end

    logic [PW-1:0]     w_pos;
    logic [KW-1:0]     w_k1;
    logic [RB:0]       w_wa;
    logic [AW+17:0]    w_sum;
    logic [AW-1:0]     n_ans;

    logic [KW-1:0]     r_k;
    logic [RB-1:0]     r_f1;
    at2i_pkg::t_ctl    r_ctl1;
    logic [AW-1:0]     r_ta;
    logic [AW-1:0]     r_tb;
    logic [RB-1:0]     r_f2;
    at2i_pkg::t_ctl    r_ctl2;
    logic [AW+16:0]    r_pa;
    logic [AW+15:0]    r_pb;
    at2i_pkg::t_ctl    r_ctl3;
    logic [AW-1:0]     r_ans;
    at2i_pkg::t_ctl    r_ctl4;

    // position in the table: ratio below one keeps k at most entries-2
    assign w_pos = PW'(i_quo) * PW'(TABLE_ENTRIES - 1);
    assign w_k1  = r_k + 1'b1;
    assign w_wa  = (RB + 1)'(1 << RB) - {1'b0, r_f2};

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_k    <= w_pos[PW-1:RB];
            r_f1   <= w_pos[RB-1:0];
            r_ctl1 <= i_ctl;
        end
        if (i_en[1]) begin
            r_ta   <= r_ctl1.steep ? w_steep[r_k]  : w_shallow[r_k];
            r_tb   <= r_ctl1.steep ? w_steep[w_k1] : w_shallow[w_k1];
            r_f2   <= r_f1;
            r_ctl2 <= r_ctl1;
        end
        if (i_en[2]) begin
            r_pa   <= (AW + 17)'(r_ta) * (AW + 17)'(w_wa);
            r_pb   <= (AW + 16)'(r_tb) * (AW + 16)'(r_f2);
            r_ctl3 <= r_ctl2;
        end
        if (i_en[3]) begin
            r_ans  <= n_ans;
            r_ctl4 <= r_ctl3;
        end
    end

    // blend with half-up rounding, equal magnitudes take the pi/4 entry
    always_comb begin
        w_sum = (AW + 18)'(r_pa) + (AW + 18)'(r_pb) + (AW + 18)'(1 << (RB - 1));
        n_ans = r_ctl3.equal ? LAST_STEEP : w_sum[AW+RB-1:RB];
    end

    assign o_ans = r_ans;
    assign o_ctl = r_ctl4;

endmodule

// ===== hw/rtl/arctangent2_table_interp_top.sv =====
// four-quadrant arctangent: each beat carries a signed (y, x) pair and returns
// atan2(y, x) in radians as signed fixed point with ANGLE_FRACTION_BITS fraction
// bits (q3.13 by default, pi = 25736). the smaller magnitude is divided by the
// larger into an unsigned q0.16 ratio, which is interpolated linearly between two
// neighboring entries of a constant atan table (one table for |y| >= |x|, one for
// |y| < |x|), then reflected into the right quadrant. (0, 0) gives 0 and equal
// magnitudes give exactly +-pi/4 or +-3pi/4. the pipeline takes one beat per
// cycle while the output is ready and has 1 magnitude stage, 8 divider stages
// at 2 quotient bits each, 4 interpolation stages (index, table read, multiply,
// blend) and 1 quadrant stage. every stage holds its own valid bit and only
// stalls when it and everything after it is full, so the input keeps taking
// beats while a result waits at the output.
module arctangent2_table_interp_top #(
    parameter int TABLE_ENTRIES       = 100,
    parameter int INPUT_WIDTH         = 16,
    parameter int ANGLE_FRACTION_BITS = 13
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    output logic                                 o_in_ready,
    input  logic signed [INPUT_WIDTH-1:0]        i_y_value,
    input  logic signed [INPUT_WIDTH-1:0]        i_x_value,
    output logic                                 o_out_valid,
    input  logic                                 i_out_ready,
    output logic signed [ANGLE_FRACTION_BITS+2:0] o_angle
);

    localparam int AW  = ANGLE_FRACTION_BITS + 3;
    localparam int RB  = at2i_pkg::RATIO_BITS;
    localparam int NDS = at2i_pkg::DIV_STAGES;
    localparam int NIS = at2i_pkg::INTERP_STAGES;
    // stage order: magnitude, divider, interpolation, quadrant
    localparam int NS  = 1 + NDS + NIS + 1;
    localparam int IS0 = 1 + NDS;
    localparam logic signed [AW-1:0] PI_ANG = AW'(at2i_pkg::pi_angle(ANGLE_FRACTION_BITS));

    // pipeline control
    logic [NS-1:0] r_vld;
    logic [NS-1:0] n_vld;
    logic [NS-1:0] w_adv;

    // a stage moves when it is empty or the one after it moves
    always_comb begin
        w_adv[NS-1] = !r_vld[NS-1] || i_out_ready;
        for (int s = NS - 2; s >= 0; s--) begin
            w_adv[s] = !r_vld[s] || w_adv[s+1];
        end
    end

    always_comb begin
        n_vld[0] = w_adv[0] ? i_in_valid : r_vld[0];
        for (int s = 1; s < NS; s++) begin
            n_vld[s] = w_adv[s] ? r_vld[s-1] : r_vld[s];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    assign o_in_ready  = w_adv[0];
    assign o_out_valid = r_vld[NS-1];

    // magnitude and octant
    logic [INPUT_WIDTH:0]   w_rem [NDS+1];
    logic [INPUT_WIDTH-1:0] w_den [NDS+1];
    logic [RB-1:0]          w_quo [NDS+1];
    at2i_pkg::t_ctl         w_ctl [NDS+1];

    at2i_front #(
        .INPUT_WIDTH (INPUT_WIDTH)
    ) u_front (
        .i_clk     (i_clk),
        .i_en      (w_adv[0]),
        .i_y_value (i_y_value),
        .i_x_value (i_x_value),
        .o_rem     (w_rem[0]),
        .o_den     (w_den[0]),
        .o_ctl     (w_ctl[0])
    );

    assign w_quo[0] = '0;

    // ratio divider, small magnitude over large one
    for (genvar d = 0; d < NDS; d++) begin : g_div
        at2i_div_step #(
            .INPUT_WIDTH (INPUT_WIDTH)
        ) u_div (
            .i_clk (i_clk),
            .i_en  (w_adv[1+d]),
            .i_rem (w_rem[d]),
            .i_den (w_den[d]),
            .i_quo (w_quo[d]),
            .i_ctl (w_ctl[d]),
            .o_rem (w_rem[d+1]),
            .o_den (w_den[d+1]),
            .o_quo (w_quo[d+1]),
            .o_ctl (w_ctl[d+1])
        );
    end

    // table lookup and linear blend
    logic [AW-1:0]  w_ans;
    at2i_pkg::t_ctl w_ans_ctl;

    at2i_interp #(
        .TABLE_ENTRIES       (TABLE_ENTRIES),
        .ANGLE_FRACTION_BITS (ANGLE_FRACTION_BITS)
    ) u_interp (
        .i_clk (i_clk),
        .i_en  (w_adv[IS0+NIS-1:IS0]),
        .i_quo (w_quo[NDS]),
        .i_ctl (w_ctl[NDS]),
        .o_ans (w_ans),
        .o_ctl (w_ans_ctl)
    );

    // quadrant: reflect for negative x, negate for negative y
    logic [AW-1:0] w_refl;
    logic [AW-1:0] n_angle;
    logic [AW-1:0] r_angle;

    always_comb begin
        w_refl = w_ans_ctl.x_neg ? (PI_ANG - w_ans) : w_ans;
        if (w_ans_ctl.zero) begin
            n_angle = '0;
        end else if (w_ans_ctl.y_neg) begin
            n_angle = AW'(0) - w_refl;
        end else begin
            n_angle = w_refl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv[NS-1]) begin
            r_angle <= n_angle;
        end
    end

    assign o_angle = r_angle;

    // an accepted beat lands in the magnitude stage
    a_accept_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> r_vld[0])
        else $error("accepted beat missing from first stage");

    // any empty stage lets the input move
    a_ready_when_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(&r_vld) |-> o_in_ready)
        else $error("input stalled with room in the pipeline");

    // result stays within -pi..pi
    a_angle_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (($signed(o_angle) <= PI_ANG) && ($signed(o_angle) >= -PI_ANG)))
        else $error("angle outside -pi..pi");

    // a stalled first interpolation stage keeps its beat
    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[IS0] && !w_adv[IS0]) |=> r_vld[IS0])
        else $error("stalled interpolation beat dropped");

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 100ps

module testbench;

    localparam int TABLE_SIZE      = 100;
    localparam int IN_BITS         = 16;
    localparam int FRAC_BITS       = 13;
    localparam int SERIES_TERMS    = 24;
    localparam int WATCHDOG_LIMIT  = 2000;
    localparam int PIPE_LATENCY    = 14;
    localparam int HOLD_OFF_CYCLES = 300;

    // arctangent constants in q0.32 for pi/4, q1.32 for pi/2 and q2.32 for pi
    localparam bit [63:0] PI_Q32         = 64'h0000_0003_243F_6A88;
    localparam bit [63:0] HALF_PI_Q32    = 64'h0000_0001_921F_B544;
    localparam bit [63:0] QUARTER_PI_Q32 = 64'h0000_0000_C90F_DAA2;

    logic i_clk = 1'b0;
    logic rst_n = 1'b0;

    // sender side
    logic                       in_valid = 1'b0;
    logic                       in_ready;
    logic signed [IN_BITS-1:0]  in_y     = '0;
    logic signed [IN_BITS-1:0]  in_x     = '0;

    // receiver side
    logic                       out_valid;
    logic                       out_ready = 1'b0;
    logic signed [FRAC_BITS+2:0] out_angle;

    // angle tables in q3.13, rebuilt here independently of the rtl
    bit [63:0] steep_tbl   [TABLE_SIZE];
    bit [63:0] shallow_tbl [TABLE_SIZE];
    bit [63:0] pi_angle;

    logic signed [FRAC_BITS+2:0] expected_angles [$];

    int error_count   = 0;
    int send_idle_pct = 24;
    int recv_idle_pct = 24;
    int hold_left     = 0;
    int quiet_cycles  = 0;

    arctangent2_table_interp_top #(
        .TABLE_ENTRIES      (TABLE_SIZE),
        .INPUT_WIDTH        (IN_BITS),
        .ANGLE_FRACTION_BITS(FRAC_BITS)
    ) DUT (
        .i_clk      (i_clk),
        .i_rst_n    (rst_n),
        .i_in_valid (in_valid),
        .o_in_ready (in_ready),
        .i_y_value  (in_y),
        .i_x_value  (in_x),
        .o_out_valid(out_valid),
        .i_out_ready(out_ready),
        .o_angle    (out_angle)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // ---------------------------------------------------------------
    // angle predictor
    // ---------------------------------------------------------------

    // atan(num/den) in q0.32 by the odd power series, valid up to one half
    function automatic bit [63:0] atan_series_q32(bit [63:0] num, bit [63:0] den);
        bit [63:0] t;
        bit [63:0] t_sq;
        bit [63:0] power;
        bit [63:0] sum;
        t     = (num << 32) / den;
        t_sq  = (t * t) >> 32;
        power = t;
        sum   = t;
        for (int n = 1; n <= SERIES_TERMS; n++) begin
            power = (power * t_sq) >> 32;
            if (n % 2 == 1) begin
                sum = sum - power / (2 * n + 1);
            end else begin
                sum = sum + power / (2 * n + 1);
            end
        end
        return sum;
    endfunction

    // q0.32 down to q3.13, rounding half up
    function automatic bit [63:0] round_to_angle(bit [63:0] v);
        return (v + (64'd1 << (31 - FRAC_BITS))) >> (32 - FRAC_BITS);
    endfunction

    function automatic void build_atan_tables();
        bit [63:0] a;
        bit [63:0] last;
        last = TABLE_SIZE - 1;
        for (int i = 0; i < TABLE_SIZE; i++) begin
            // above one half, fold around pi/4 so the series converges fast
            if (2 * i <= last) begin
                a = atan_series_q32(i, last);
            end else begin
                a = QUARTER_PI_Q32 - atan_series_q32(last - i, last + i);
            end
            shallow_tbl[i] = round_to_angle(a);
            steep_tbl[i]   = round_to_angle(HALF_PI_Q32 - a);
        end
        pi_angle = round_to_angle(PI_Q32);
    endfunction

    // linear blend between neighbors, ratio in q0.16
    function automatic bit [63:0] interp_table(bit use_steep, bit [63:0] ratio);
        bit [63:0] pos;
        bit [63:0] k;
        bit [63:0] f;
        bit [63:0] lo;
        bit [63:0] hi;
        pos = ratio * (TABLE_SIZE - 1);
        k   = pos >> 16;
        f   = pos & 64'hFFFF;
        if (k >= TABLE_SIZE - 1) begin
            return use_steep ? steep_tbl[TABLE_SIZE-1] : shallow_tbl[TABLE_SIZE-1];
        end
        lo = use_steep ? steep_tbl[k]   : shallow_tbl[k];
        hi = use_steep ? steep_tbl[k+1] : shallow_tbl[k+1];
        return (lo * (65536 - f) + hi * f + 32768) >> 16;
    endfunction

    function automatic logic signed [FRAC_BITS+2:0] atan2_angle(
        logic signed [IN_BITS-1:0] y, logic signed [IN_BITS-1:0] x);
        int        yi;
        int        xi;
        bit [63:0] ay;
        bit [63:0] ax;
        bit [63:0] a;
        yi = y;
        xi = x;
        // the most negative input keeps its full magnitude here
        ay = (yi < 0) ? -yi : yi;
        ax = (xi < 0) ? -xi : xi;
        if (ay == 0 && ax == 0) begin
            return '0;
        end
        if (ay >= ax) begin
            // equal magnitudes take pi/4 straight from the last steep entry
            if (ay == ax) begin
                a = steep_tbl[TABLE_SIZE-1];
            end else begin
                a = interp_table(1'b1, (ax << 16) / ay);
            end
        end else begin
            a = interp_table(1'b0, (ay << 16) / ax);
        end
        // quadrant fold: left half mirrors about pi/2, lower half negates
        if (xi < 0) begin
            a = pi_angle - a;
        end
        if (yi < 0) begin
            a = -a;
        end
        return a[FRAC_BITS+2:0];
    endfunction

    // ---------------------------------------------------------------
    // monitor: records accepted input beats and checks output beats
    // ---------------------------------------------------------------
    initial begin
        logic signed [FRAC_BITS+2:0] want_angle;
        forever begin
            @(posedge i_clk);
            if (in_valid && in_ready) begin
                expected_angles.push_back(atan2_angle(in_y, in_x));
            end
            if (out_valid && out_ready) begin
                if (expected_angles.size() == 0) begin
                    $error("angle: unexpected beat, expected none, actual %0d", out_angle);
                    error_count++;
                end else begin
                    want_angle = expected_angles.pop_front();
                    if (out_angle !== want_angle) begin
                        $error("angle mismatch: expected %0d, actual %0d",
                               want_angle, out_angle);
                        error_count++;
                    end
                end
            end
        end
    end

    // receiver: random stalls, plus a counted hold-off when a test asks for one
    initial begin
        forever begin
            @(posedge i_clk);
            if (hold_left > 0) begin
                out_ready <= 1'b0;
                hold_left--;
            end else begin
                out_ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    // watchdog on cycles with no beat on either side
    initial begin
        while (quiet_cycles < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((in_valid && in_ready) || (out_valid && out_ready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
        end
        $display("CHECKS FAILED");
        $finish;
    end

    // ---------------------------------------------------------------
    // stimulus helpers
    // ---------------------------------------------------------------

    // offer one (y, x) beat and hold it until it is taken
    task automatic send_pair(input int y, input int x);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_y     <= y[IN_BITS-1:0];
        in_x     <= x[IN_BITS-1:0];
        do @(posedge i_clk); while (!in_ready);
    endtask

    // stop offering and wait for every outstanding angle
    task automatic wait_all_angles();
        in_valid <= 1'b0;
        while (expected_angles.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    // signed component from a magnitude, clamped to the positive limit
    function automatic int signed_mag(int m, bit neg);
        if (!neg && m > 32767) begin
            return 32767;
        end
        return neg ? -m : m;
    endfunction

    task automatic random_pair(output int y, output int x);
        int  pick;
        int  m;
        int  d;
        bit [31:0] r;
        pick = $urandom_range(9);
        r    = $urandom;
        case (pick)
            0, 1, 2, 3: begin
                y = $signed(r[15:0]);
                x = $signed(r[31:16]);
            end
            4, 5: begin
                y = int'($urandom_range(32)) - 16;
                x = int'($urandom_range(32)) - 16;
            end
            6, 7: begin
                // near-equal magnitudes, around the octant boundary
                m = $urandom_range(1, 32768);
                d = $urandom_range(0, 2);
                y = signed_mag(m, r[0]);
                x = signed_mag((m + d > 32768) ? m - d : m + d, r[1]);
                if (r[2]) begin
                    m = y;
                    y = x;
                    x = m;
                end
            end
            8: begin
                // one axis at zero, at +-1 or at an extreme
                case (r[2:0])
                    3'd0, 3'd1: m = 0;
                    3'd2:       m = 32767;
                    3'd3:       m = -32768;
                    3'd4:       m = 1;
                    default:    m = -1;
                endcase
                if (r[3]) begin
                    y = m;
                    x = $signed(r[31:16]);
                end else begin
                    x = m;
                    y = $signed(r[31:16]);
                end
            end
            default: begin
                // tiny against large, ratio near zero
                y = int'($urandom_range(8)) - 4;
                x = $signed(r[31:16]);
                if (r[0]) begin
                    m = y;
                    y = x;
                    x = m;
                end
            end
        endcase
    endtask

    // ---------------------------------------------------------------
    // tests
    // ---------------------------------------------------------------

    task automatic test_special_cases();
        send_pair(0, 0);              // origin gives zero
        send_pair(0, 1);
        send_pair(0, -1);             // +pi on the negative x axis
        send_pair(0, -32768);
        send_pair(1, 0);
        send_pair(-1, 0);
        send_pair(32767, 0);
        send_pair(-32768, 0);
        send_pair(5, 5);              // equal magnitudes in all quadrants
        send_pair(-5, 5);
        send_pair(5, -5);
        send_pair(-5, -5);
        send_pair(32767, 32767);
        send_pair(-32768, -32768);    // most negative on both sides
        send_pair(-32768, 32767);
        send_pair(32767, -32768);
        send_pair(1, 32767);
        send_pair(32767, 1);
        send_pair(-1, -32768);
        send_pair(-32768, -1);
        send_pair(32767, 32766);
        send_pair(-32767, 32768 - 1);
        send_pair(100, -3);
        send_pair(-3, -100);
    endtask

    task automatic test_random_pairs(input int count);
        int y;
        int x;
        for (int i = 0; i < count; i++) begin
            // a long stretch with both sides streaming flat out
            if (i == count / 3) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end else if (i == count / 3 + 300) begin
                send_idle_pct = 24;
                recv_idle_pct = 24;
            end
            random_pair(y, x);
            send_pair(y, x);
        end
    endtask

    // receiver holds off long enough for the pipe to fill and stall the input
    task automatic test_output_hold_off();
        int y;
        int x;
        hold_left = HOLD_OFF_CYCLES;
        for (int i = 0; i < 150; i++) begin
            random_pair(y, x);
            send_pair(y, x);
        end
    endtask

    // sender stops until the pipe is empty, then resumes
    task automatic test_sender_pause();
        int y;
        int x;
        for (int i = 0; i < 120; i++) begin
            if (i == 60) begin
                wait_all_angles();
            end
            random_pair(y, x);
            send_pair(y, x);
        end
    endtask

    initial begin
        build_atan_tables();
        repeat (2) @(posedge i_clk);
        rst_n <= 1'b1;

        test_special_cases();
        test_random_pairs(1300);
        test_output_hold_off();
        test_sender_pause();

        wait_all_angles();
        repeat (PIPE_LATENCY + 6) @(posedge i_clk);
        if (expected_angles.size() != 0) begin
            $error("angle: %0d expected beats never arrived", expected_angles.size());
            error_count++;
        end
        if (error_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
